>>> hdl/aik_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the arm inverse kinematics core.
// Holds the CORDIC arctangent table and the cell payload structs; no dependencies.
package aik_pkg;

	// CORDIC depth; the arctangent table has 24 entries, so the chain is capped there
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int NSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	// datapath widths
	localparam int CX_W = 34;       // CORDIC x/y lengths, Q18.16 in the rotation chain, Q26.8 in the vectoring chains
	localparam int CZ_W = 28;       // CORDIC angle, Q24 radians
	localparam int TH_W = 28;       // servo-arm angle, Q24 radians
	localparam int R2_W = 52;       // squared radius, Q36.16
	localparam int RT_W = R2_W / 2; // square root result, Q18.8
	localparam int SH_W = 5;        // CORDIC shift index

	// angle constants in Q24 radians
	localparam logic signed [TH_W:0] PI_Q24      = 29'sd52707179;
	localparam logic signed [TH_W:0] TWO_PI_Q24  = 29'sd105414357;
	localparam logic signed [TH_W:0] HALF_PI_Q24 = 29'sd26353589;

	// CORDIC gain 0.6072529 in Q24
	localparam logic [23:0] GAIN_Q24 = 24'd10188014;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LOWER_ARM_LENGTH     = 2'd0,
		REG_SERVO_ANGLE_OFFSET   = 2'd1,
		REG_ACTUATOR_BASE_LENGTH = 2'd2,
		REG_ACTUATOR_SIDE_OFFSET = 2'd3
	} cfg_reg_t;

	// one CORDIC cell's working set
	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [CZ_W-1:0] z;
	} cordic_t;

	// one square root cell's working set
	typedef struct packed {
		logic [R2_W-1:0] rad;
		logic [RT_W+1:0] rem;
		logic [RT_W-1:0] root;
	} sqrt_t;

	// atan(2^-i) in Q24
	function automatic logic signed [CZ_W-1:0] atan_q24(input logic [SH_W-1:0] idx);
		logic signed [CZ_W-1:0] a;
		case (idx)
			5'd0:    a = 28'sd13176795;
			5'd1:    a = 28'sd7778716;
			5'd2:    a = 28'sd4110060;
			5'd3:    a = 28'sd2086331;
			5'd4:    a = 28'sd1047214;
			5'd5:    a = 28'sd524117;
			5'd6:    a = 28'sd262123;
			5'd7:    a = 28'sd131069;
			5'd8:    a = 28'sd65536;
			5'd9:    a = 28'sd32768;
			5'd10:   a = 28'sd16384;
			5'd11:   a = 28'sd8192;
			5'd12:   a = 28'sd4096;
			5'd13:   a = 28'sd2048;
			5'd14:   a = 28'sd1024;
			5'd15:   a = 28'sd512;
			5'd16:   a = 28'sd256;
			5'd17:   a = 28'sd128;
			5'd18:   a = 28'sd64;
			5'd19:   a = 28'sd32;
			5'd20:   a = 28'sd16;
			5'd21:   a = 28'sd8;
			5'd22:   a = 28'sd4;
			5'd23:   a = 28'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> hdl/arm_inverse_kinematics_core.sv
`timescale 1ns / 1ps
// Top level of the arm inverse kinematics core: config registers, pipeline and stream ports.
// Depends on aik_pkg, aik_cordic_cell and aik_sqrt_cell.

// The core takes one target (x, y, bottom servo angle) per clock unless the output stalls,
// and returns one result per target, in order. The pipeline holds three chains of cells:
// a rotation CORDIC that places the lower arm end, a one-bit-per-cell square root of
// r^2 - side^2, and two vectoring CORDICs that run side by side for the two arctangents.
// The whole pipeline advances together and holds only when the output register is full
// and the sink does not take the result.
// Configuration must be written while no target is in flight.
module arm_inverse_kinematics_core import aik_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // target_x[15:0], target_y[31:16], bottom_servo_angle[47:32]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // actuator_extension[15:0], top_servo_angle[33:16], zero
	output logic [1:0]  m_tuser,   // out_of_reach[0], singular_dx[1]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DX_W  = 27;
	localparam int NUM_W = CX_W + 1;
	localparam int TOP_W = 30;
	localparam int EXT_W = 21;
	localparam int L     = 2 * NSTG + RT_W + 10;

	typedef struct packed {
		logic signed [15:0]     tx;
		logic signed [15:0]     ty;
		logic signed [TH_W-1:0] theta;
		logic                   neg;
	} rot_sb_t;

	typedef struct packed {
		logic signed [DX_W-1:0] dx;
		logic signed [DX_W-1:0] dy;
		logic                   sing;
		logic                   oor;
		logic signed [TH_W-1:0] theta;
	} sq_sb_t;

	typedef struct packed {
		logic signed [TH_W-1:0] theta;
		logic                   sing;
		logic                   oor;
		logic                   dy_neg;
		logic                   ts_zero;
		logic [RT_W-1:0]        h;
	} vc_sb_t;

	// configuration registers
	logic [14:0]        lower_arm_length_q;
	logic signed [15:0] servo_angle_offset_q;
	logic [14:0]        actuator_base_length_q;
	logic [14:0]        actuator_side_offset_q;

	// pipeline control
	logic [L-1:0] vld_q;
	logic         en;

	// front stages
	logic signed [16:0]     adiff;
	logic [38:0]            gain_prod;
	logic signed [15:0]     tx_s1, ty_s1, tx_s2, ty_s2;
	logic signed [TH_W-1:0] theta_s1, theta_s2, z_s2;
	logic [30:0]            xw0_s1, xw0_s2;
	logic signed [TH_W:0]   thx, zw, zx, zf;
	logic                   negf;
	cordic_t                rot_s3;

	// chains
	wire cordic_t rot [0:NSTG];
	wire cordic_t vu  [0:NSTG];
	wire cordic_t vs  [0:NSTG];
	wire sqrt_t   sq  [0:RT_W];
	rot_sb_t      rsb_q [0:NSTG];
	sq_sb_t       ssb_q [0:RT_W];
	vc_sb_t       vsb_q [0:NSTG];

	// middle stages
	logic [NUM_W-1:0]         xe, ye, numx, numy;
	logic signed [DX_W-1:0]   dx_s4, dy_s4, dx_s5, dy_s5, dx_s6, dy_s6;
	logic signed [TH_W-1:0]   theta_s4, theta_s5, theta_s6;
	logic signed [2*DX_W-1:0] px, py;
	logic [29:0]              ssq;
	logic [R2_W-1:0]          sqx_s5, sqy_s5, s2sq_s5, r2_s6, s2sq_s6;
	logic                     sing_s5, sing_s6;
	sqrt_t                    sq_s7;

	// back stages
	logic signed [CX_W-1:0]  dxe, dye;
	cordic_t                 vu_s8, vs_s8;
	logic                    negx;
	logic signed [CZ_W-1:0]  tu;
	logic signed [TOP_W-1:0] top_sum;
	logic [RT_W:0]           hr;
	logic signed [TOP_W-1:0] top_s9, tr;
	logic signed [EXT_W-1:0] ext_s9;
	logic                    oor_s9, sing_s9;
	logic signed [TOP_W-12:0] tq;
	logic signed [15:0]      ext_q;
	logic signed [17:0]      top_q;
	logic                    oor_q, sing_q;

	// config write port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_arm_length_q     <= 15'd2000;
			servo_angle_offset_q   <= 16'sd860;
			actuator_base_length_q <= 15'd2368;
			actuator_side_offset_q <= 15'd384;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOWER_ARM_LENGTH:     lower_arm_length_q     <= cfg_data[14:0];
				REG_SERVO_ANGLE_OFFSET:   servo_angle_offset_q   <= cfg_data;
				REG_ACTUATOR_BASE_LENGTH: actuator_base_length_q <= cfg_data[14:0];
				REG_ACTUATOR_SIDE_OFFSET: actuator_side_offset_q <= cfg_data[14:0];
			endcase
		end
	end

	// advance everything unless the output holds an untaken result
	assign en       = ~vld_q[L-1] | m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	// s1: capture the target, lower arm angle and scaled arm length
	assign adiff     = {s_tdata[47], s_tdata[47:32]} - {servo_angle_offset_q[15], servo_angle_offset_q};
	assign gain_prod = 39'(lower_arm_length_q) * 39'(GAIN_Q24);

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1    <= s_tdata[15:0];
			ty_s1    <= s_tdata[31:16];
			theta_s1 <= {adiff, 11'b0};
			xw0_s1   <= gain_prod[38:8];
		end
	end

	// s2: wrap the angle into [-pi, pi]
	always_comb begin
		thx = {theta_s1[TH_W-1], theta_s1};
		if (thx > PI_Q24) begin
			zw = thx - TWO_PI_Q24;
		end else if (thx < -PI_Q24) begin
			zw = thx + TWO_PI_Q24;
		end else begin
			zw = thx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s2    <= tx_s1;
			ty_s2    <= ty_s1;
			theta_s2 <= theta_s1;
			z_s2     <= zw[TH_W-1:0];
			xw0_s2   <= xw0_s1;
		end
	end

	// s3: fold into [-pi/2, pi/2], remembering the sign flip
	always_comb begin
		zx = {z_s2[TH_W-1], z_s2};
		if (zx > HALF_PI_Q24) begin
			zf   = zx - PI_Q24;
			negf = 1'b1;
		end else if (zx < -HALF_PI_Q24) begin
			zf   = zx + PI_Q24;
			negf = 1'b1;
		end else begin
			zf   = zx;
			negf = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s3.x <= CX_W'(xw0_s2);
			rot_s3.y <= '0;
			rot_s3.z <= zf[CZ_W-1:0];
		end
	end

	// sideband of the rotation chain, shifted along with the cells
	always_ff @(posedge clk) begin
		if (en) begin
			rsb_q[0] <= '{tx: tx_s2, ty: ty_s2, theta: theta_s2, neg: negf};
			for (int k = 0; k < NSTG; k++) begin
				rsb_q[k+1] <= rsb_q[k];
			end
		end
	end

	// rotation CORDIC chain: lower arm end
	assign rot[0] = rot_s3;

	for (genvar k = 0; k < NSTG; k++) begin : g_rot
		aik_cordic_cell u_cell (
			.clk      (clk),
			.en       (en),
			.vec_mode (1'b0),
			.shift    (SH_W'(k)),
			.din      (rot[k]),
			.dout     (rot[k+1])
		);
	end

	// s4: upper arm vector, rounded to Q19.8
	always_comb begin
		xe   = {rot[NSTG].x[CX_W-1], rot[NSTG].x};
		ye   = {rot[NSTG].y[CX_W-1], rot[NSTG].y};
		numx = {{(NUM_W-32){rsb_q[NSTG].tx[15]}}, rsb_q[NSTG].tx, 16'b0}
			+ (rsb_q[NSTG].neg ? xe : -xe) + NUM_W'(128);
		numy = {{(NUM_W-32){rsb_q[NSTG].ty[15]}}, rsb_q[NSTG].ty, 16'b0}
			+ (rsb_q[NSTG].neg ? ye : -ye) + NUM_W'(128);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s4    <= numx[NUM_W-1:8];
			dy_s4    <= numy[NUM_W-1:8];
			theta_s4 <= rsb_q[NSTG].theta;
		end
	end

	// s5: squares
	assign px  = dx_s4 * dx_s4;
	assign py  = dy_s4 * dy_s4;
	assign ssq = actuator_side_offset_q * actuator_side_offset_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s5   <= px[R2_W-1:0];
			sqy_s5   <= py[R2_W-1:0];
			s2sq_s5  <= R2_W'({ssq, 16'b0});
			sing_s5  <= (dx_s4 == '0);
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			theta_s5 <= theta_s4;
		end
	end

	// s6: squared radius
	always_ff @(posedge clk) begin
		if (en) begin
			r2_s6    <= sqx_s5 + sqy_s5;
			s2sq_s6  <= s2sq_s5;
			sing_s6  <= sing_s5;
			dx_s6    <= dx_s5;
			dy_s6    <= dy_s5;
			theta_s6 <= theta_s5;
		end
	end

	// s7: reach check and radicand; sideband of the square root chain
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s7.rad  <= r2_s6 - s2sq_s6;
			sq_s7.rem  <= '0;
			sq_s7.root <= '0;
			ssb_q[0]   <= '{dx: dx_s6, dy: dy_s6, sing: sing_s6,
				oor: (r2_s6 < s2sq_s6), theta: theta_s6};
			for (int k = 0; k < RT_W; k++) begin
				ssb_q[k+1] <= ssb_q[k];
			end
		end
	end

	// square root chain: actuator reach
	assign sq[0] = sq_s7;

	for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
		aik_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (sq[k]),
			.dout (sq[k+1])
		);
	end

	// s8: vectoring inputs, mirrored into the right half plane
	always_comb begin
		dxe  = CX_W'(ssb_q[RT_W].dx);
		dye  = CX_W'(ssb_q[RT_W].dy);
		negx = ssb_q[RT_W].dx[DX_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vu_s8.x <= negx ? -dxe : dxe;
			vu_s8.y <= negx ? -dye : dye;
			vu_s8.z <= '0;
			vs_s8.x <= CX_W'({actuator_side_offset_q, 8'b0});
			vs_s8.y <= CX_W'(sq[RT_W].root);
			vs_s8.z <= '0;
			vsb_q[0] <= '{theta: ssb_q[RT_W].theta, sing: ssb_q[RT_W].sing,
				oor: ssb_q[RT_W].oor, dy_neg: ssb_q[RT_W].dy[DX_W-1],
				ts_zero: (actuator_side_offset_q == '0) && (sq[RT_W].root == '0),
				h: sq[RT_W].root};
			for (int k = 0; k < NSTG; k++) begin
				vsb_q[k+1] <= vsb_q[k];
			end
		end
	end

	// vectoring CORDIC chains: upper arm angle and side offset angle
	assign vu[0] = vu_s8;
	assign vs[0] = vs_s8;

	for (genvar k = 0; k < NSTG; k++) begin : g_vec
		aik_cordic_cell u_cell_u (
			.clk      (clk),
			.en       (en),
			.vec_mode (1'b1),
			.shift    (SH_W'(k)),
			.din      (vu[k]),
			.dout     (vu[k+1])
		);
		aik_cordic_cell u_cell_s (
			.clk      (clk),
			.en       (en),
			.vec_mode (1'b1),
			.shift    (SH_W'(k)),
			.din      (vs[k]),
			.dout     (vs[k+1])
		);
	end

	// s9: angle sum and raw extension
	always_comb begin
		if (vsb_q[NSTG].sing) begin
			tu = vsb_q[NSTG].dy_neg ? -CZ_W'(HALF_PI_Q24) : CZ_W'(HALF_PI_Q24);
		end else begin
			tu = vu[NSTG].z;
		end
		top_sum = TOP_W'(tu) + TOP_W'(HALF_PI_Q24) - TOP_W'(vsb_q[NSTG].theta);
		if (!vsb_q[NSTG].ts_zero) begin
			top_sum = top_sum + TOP_W'(vs[NSTG].z);
		end
		hr = {1'b0, vsb_q[NSTG].h} + (RT_W+1)'(128);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			top_s9  <= top_sum;
			ext_s9  <= EXT_W'(hr[RT_W:8]) - EXT_W'(actuator_base_length_q);
			oor_s9  <= vsb_q[NSTG].oor;
			sing_s9 <= vsb_q[NSTG].sing;
		end
	end

	// output register: round, clamp, zero when out of reach
	assign tr = top_s9 + TOP_W'(1024);
	assign tq = tr[TOP_W-1:11];

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q  <= oor_s9;
			sing_q <= sing_s9;
			if (oor_s9) begin
				ext_q <= '0;
				top_q <= '0;
			end else begin
				if (ext_s9 > EXT_W'(32767)) begin
					ext_q <= 16'sh7FFF;
				end else if (ext_s9 < -EXT_W'(32768)) begin
					ext_q <= 16'sh8000;
				end else begin
					ext_q <= ext_s9[15:0];
				end
				if (tq > (TOP_W-11)'(131071)) begin
					top_q <= 18'sh1FFFF;
				end else if (tq < -(TOP_W-11)'(131072)) begin
					top_q <= 18'sh20000;
				end else begin
					top_q <= tq[17:0];
				end
			end
		end
	end

	assign m_tdata = {6'b0, top_q, ext_q};
	assign m_tuser = {sing_q, oor_q};

endmodule

>>> hdl/aik_cordic_cell.sv
`timescale 1ns / 1ps
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on aik_pkg for cordic_t and the arctangent table.
module aik_cordic_cell import aik_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic            vec_mode,
	input  logic [SH_W-1:0] shift,
	input  cordic_t         din,
	output cordic_t         dout
);

	logic signed [CX_W-1:0] x_in;
	logic signed [CX_W-1:0] y_in;
	logic signed [CZ_W-1:0] z_in;
	logic signed [CX_W-1:0] xs;
	logic signed [CX_W-1:0] ys;
	logic signed [CZ_W-1:0] ang;
	logic                   ccw;
	cordic_t                nxt;

	// pick the direction and rotate by atan(2^-shift)
	always_comb begin
		x_in = din.x;
		y_in = din.y;
		z_in = din.z;
		xs   = x_in >>> shift;
		ys   = y_in >>> shift;
		ang  = atan_q24(shift);
		ccw  = vec_mode ? y_in[CX_W-1] : ~z_in[CZ_W-1];
		if (ccw) begin
			nxt.x = x_in - ys;
			nxt.y = y_in + xs;
			nxt.z = z_in - ang;
		end else begin
			nxt.x = x_in + ys;
			nxt.y = y_in - xs;
			nxt.z = z_in + ang;
		end
	end

	// hand the result to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

>>> hdl/aik_sqrt_cell.sv
`timescale 1ns / 1ps
// One registered digit of a restoring integer square root (one result bit per cell).
// Depends on aik_pkg for sqrt_t.
module aik_sqrt_cell import aik_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  sqrt_t din,
	output sqrt_t dout
);

	logic [RT_W+1:0] rem_sh;
	logic [RT_W+1:0] trial;
	sqrt_t           nxt;

	// bring in the next two radicand bits and try the next root bit
	always_comb begin
		rem_sh  = {din.rem[RT_W-1:0], din.rad[R2_W-1 -: 2]};
		trial   = {din.root, 2'b01};
		nxt.rad = {din.rad[R2_W-3:0], 2'b00};
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {din.root[RT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {din.root[RT_W-2:0], 1'b0};
		end
	end

	// hand the partial root to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule
